[hw/rtl/two_choice_load_balancer_macros.svh]
// assertion macros shared by the load balancer rtl
`ifndef TWO_CHOICE_LOAD_BALANCER_MACROS_SVH
`define TWO_CHOICE_LOAD_BALANCER_MACROS_SVH

`ifndef SYNTHESIS
`define TCLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tclb assertion failed");
`define TCLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tclb assertion failed");
`else
`define TCLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/tclb_pkg.sv]
// types, constants and helpers of the two-choice load balancer
package tclb_pkg;

	localparam int MAX_WORKERS_DEF = 16;

	localparam int ITEM_SIZE_W = 40;
	localparam int LOAD_W      = 48;
	localparam int COUNT_W     = 32;
	localparam int WORKER_W    = 4;
	localparam int WC_W        = 5;
	localparam int SEED_W      = 32;
	localparam int DRAW_W      = WC_W;
	localparam int TRIES_W     = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam int REDRAW_LIMIT = 256;

	localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'h8020_0003;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
	localparam logic [WC_W-1:0]   WC_RESET   = 5'd4;

	localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 1'b1;

	typedef struct packed {
		logic [ITEM_SIZE_W-1:0] item_size;
		logic                   last_item;
	} tclb_item_t;

	typedef struct packed {
		logic [WORKER_W-1:0] chosen_worker;
		logic [LOAD_W-1:0]   worker_load;
		logic [COUNT_W-1:0]  worker_items;
		logic                last_item_res;
	} tclb_result_t;

	// one table entry: accumulated load and item count of a worker
	typedef struct packed {
		logic [LOAD_W-1:0]  load;
		logic [COUNT_W-1:0] count;
	} tclb_rec_t;

	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

[hw/rtl/tclb_ram.sv]
// generic single-write, single-read ram with registered read data
module tclb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tclb_mod_unit.sv]
// iterative remainder unit: one dividend bit per cycle
`include "two_choice_load_balancer_macros.svh"

module tclb_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tclb_pkg::SEED_W-1:0] dividend,
	input  logic [tclb_pkg::DRAW_W-1:0] divisor,
	output logic                        done,
	output logic [tclb_pkg::DRAW_W-1:0] remainder
);

	import tclb_pkg::*;

	localparam int STEP_W = $clog2(SEED_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SEED_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SEED_W-1:0] quot_q;
	logic [DRAW_W-1:0] rem_q;
	logic [DRAW_W-1:0] div_q;

	logic [DRAW_W:0]   trial;
	logic [DRAW_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, quot_q[SEED_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = DRAW_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[DRAW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (run_q) begin
			quot_q <= quot_q << 1;
			rem_q  <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	`TCLB_ASSERT_IMP(a_start_when_free, clk, arst_n, start, !run_q)
	`TCLB_ASSERT_NXT(a_done_after_last, clk, arst_n, run_q && cnt_q == LAST_STEP, done_q)
	`TCLB_ASSERT_IMP(a_rem_in_range, clk, arst_n, done_q, rem_q < div_q)

endmodule

[hw/rtl/two_choice_load_balancer.sv]
// two-choice load balancer: lfsr draws, shared modulo unit, worker table ram
// after an accepted start: draw a, draw b (repeated per redraw), table reads, pick, update, then the result strobe
// each of the two draws costs one lfsr step and one pass of the shared modulo unit
// a new item is accepted in the cycle the previous result is strobed
// after reset a clearing pass zeroes every table entry, busy stays high
// results are strobed for one cycle; the receiver cannot stall
`include "two_choice_load_balancer_macros.svh"

module two_choice_load_balancer #(
	parameter int MAX_WORKERS = tclb_pkg::MAX_WORKERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tclb_pkg::tclb_item_t            item,
	output logic                            result_valid,
	output tclb_pkg::tclb_result_t          result,
	input  logic                            cfg_we,
	input  logic [tclb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tclb_pkg::CFG_DATA_W-1:0] cfg_data
);

	import tclb_pkg::*;

	localparam int IDX_W = $clog2(MAX_WORKERS);
	localparam int REC_W = $bits(tclb_rec_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WORKERS - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DRAW_A = 3'd2;
	localparam logic [2:0] ST_DRAW_B = 3'd3;
	localparam logic [2:0] ST_RD_A   = 3'd4;
	localparam logic [2:0] ST_RD_B   = 3'd5;
	localparam logic [2:0] ST_PICK   = 3'd6;
	localparam logic [2:0] ST_UPD    = 3'd7;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [WC_W-1:0]    wc_q;
	logic [SEED_W-1:0]  random_q;
	logic [DRAW_W-1:0]  n_q;
	tclb_item_t         item_q;
	logic [DRAW_W-1:0]  first_q;
	logic [DRAW_W-1:0]  second_q;
	logic [TRIES_W-1:0] tries_q;
	logic [DRAW_W-1:0]  pick_q;
	tclb_rec_t          rec_a_q;
	tclb_rec_t          rec_sel_q;
	tclb_result_t       result_q;
	logic               result_valid_q;

	logic [DRAW_W-1:0]  active_n;
	logic [SEED_W-1:0]  lfsr_next;
	logic               mod_start;
	logic               mod_done;
	logic [DRAW_W-1:0]  mod_rem;
	logic [DRAW_W-1:0]  mod_div;
	logic               redraw;
	logic [DRAW_W:0]    first_inc;
	logic [DRAW_W-1:0]  second_alt;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [REC_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [REC_W-1:0]   ram_rdata;
	tclb_rec_t          rec_b;
	tclb_rec_t          rec_new;
	logic [LOAD_W:0]    load_sum;

	logic [IDX_W+DRAW_W-1:0] a_ext;
	logic [IDX_W+DRAW_W-1:0] b_ext;
	logic [IDX_W+DRAW_W-1:0] p_ext;

	// active worker count: zero reads as one, clipped to the built table
	always_comb begin
		active_n = wc_q;
		if (wc_q == '0) begin
			active_n = DRAW_W'(1);
		end else if (32'(wc_q) > MAX_WORKERS) begin
			active_n = DRAW_W'(MAX_WORKERS);
		end
	end

	assign lfsr_next = lfsr_step(random_q);
	assign mod_div   = (state_q == ST_IDLE) ? active_n : n_q;

	assign redraw = (n_q != DRAW_W'(1)) && (mod_rem == first_q)
		&& (tries_q < TRIES_W'(REDRAW_LIMIT));

	always_comb begin
		mod_start = 1'b0;
		case (state_q)
			ST_IDLE:   mod_start = start;
			ST_DRAW_A: mod_start = mod_done;
			ST_DRAW_B: mod_start = mod_done && redraw;
			default:   mod_start = 1'b0;
		endcase
	end

	// forced second index once the redraw budget is spent
	assign first_inc  = {1'b0, first_q} + 1'b1;
	assign second_alt = (first_inc == {1'b0, n_q}) ? '0 : first_inc[DRAW_W-1:0];

	tclb_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (lfsr_next),
		.divisor   (mod_div),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign a_ext = {{IDX_W{1'b0}}, first_q};
	assign b_ext = {{IDX_W{1'b0}}, second_q};
	assign p_ext = {{IDX_W{1'b0}}, pick_q};

	assign rec_b     = tclb_rec_t'(ram_rdata);
	assign ram_raddr = (state_q == ST_RD_A) ? a_ext[IDX_W-1:0] : b_ext[IDX_W-1:0];

	// saturating update of the chosen worker
	always_comb begin
		load_sum = {1'b0, rec_sel_q.load} + (LOAD_W + 1)'(item_q.item_size);
		rec_new.load  = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
		rec_new.count = (&rec_sel_q.count) ? rec_sel_q.count : rec_sel_q.count + 1'b1;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_ext[IDX_W-1:0];
		ram_wdata = REC_W'(rec_new);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_UPD) begin
			ram_we = 1'b1;
		end
	end

	tclb_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_WORKERS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers and the random generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= WC_RESET;
			random_q <= SEED_RESET;
		end else begin
			if (mod_start) begin
				random_q <= lfsr_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WORKER_COUNT: wc_q <= cfg_data[WC_W-1:0];
					REG_RANDOM_SEED: begin
						random_q <= (cfg_data == '0) ? SEED_RESET : cfg_data;
					end
					default: ;
				endcase
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DRAW_A;
					end
				end
				ST_DRAW_A: begin
					if (mod_done) begin
						state_q <= ST_DRAW_B;
					end
				end
				ST_DRAW_B: begin
					if (mod_done && !redraw) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_PICK;
				ST_PICK: state_q <= ST_UPD;
				ST_UPD: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload, draws and table records
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q  <= item;
					n_q     <= active_n;
					tries_q <= '0;
				end
			end
			ST_DRAW_A: begin
				if (mod_done) begin
					first_q <= mod_rem;
				end
			end
			ST_DRAW_B: begin
				if (mod_done) begin
					second_q <= mod_rem;
					if (redraw) begin
						tries_q <= tries_q + 1'b1;
					end else if (n_q != DRAW_W'(1) && mod_rem == first_q) begin
						second_q <= second_alt;
					end
				end
			end
			ST_RD_B: rec_a_q <= tclb_rec_t'(ram_rdata);
			ST_PICK: begin
				// tie goes to the first draw
				if (rec_a_q.load > rec_b.load) begin
					pick_q    <= second_q;
					rec_sel_q <= rec_b;
				end else begin
					pick_q    <= first_q;
					rec_sel_q <= rec_a_q;
				end
			end
			ST_UPD: begin
				result_q.chosen_worker <= pick_q[WORKER_W-1:0];
				result_q.worker_load   <= rec_new.load;
				result_q.worker_items  <= rec_new.count;
				result_q.last_item_res <= item_q.last_item;
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TCLB_ASSERT_NXT(a_single_strobe, clk, arst_n, result_valid_q, !result_valid_q)
	`TCLB_ASSERT_IMP(a_pick_in_range, clk, arst_n, result_valid_q, DRAW_W'(result_q.chosen_worker) < n_q)
	`TCLB_ASSERT_IMP(a_draws_differ, clk, arst_n, state_q == ST_RD_A, (first_q != second_q) || (n_q == DRAW_W'(1)))
	`TCLB_ASSERT_IMP(a_lfsr_nonzero, clk, arst_n, 1'b1, random_q != '0)

endmodule

[sim/tclb_placement_checker.sv]
// checker that predicts the worker placements of the load balancer and compares the results
module tclb_placement_checker #(
	parameter int MAX_WORKERS = tclb_pkg::MAX_WORKERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  tclb_pkg::tclb_item_t            item,
	input  logic                            result_valid,
	input  tclb_pkg::tclb_result_t          result,
	input  logic                            cfg_we,
	input  logic [tclb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tclb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import tclb_pkg::*;

	logic [WC_W-1:0]    wc_reg;
	logic [SEED_W-1:0]  rng;
	logic [LOAD_W-1:0]  load_tab [MAX_WORKERS];
	logic [COUNT_W-1:0] count_tab [MAX_WORKERS];
	tclb_result_t       expected_placements [$];
	int                 mismatches = 0;

	function automatic int active_workers(input logic [WC_W-1:0] wc);
		if (wc == '0) return 1;
		if (int'(wc) > MAX_WORKERS) return MAX_WORKERS;
		return int'(wc);
	endfunction

	// one generator step, then reduce the new state to a worker index
	function automatic int draw_worker(input int n);
		logic lsb;
		lsb = rng[0];
		rng = rng >> 1;
		if (lsb) begin
			rng = rng ^ LFSR_TAPS;
		end
		return int'(rng % SEED_W'(n));
	endfunction

	task automatic place_item(input tclb_item_t it, output tclb_result_t r);
		int n;
		int first;
		int second;
		int pick;
		int tries;
		logic [LOAD_W:0] sum;
		n = active_workers(wc_reg);
		first = draw_worker(n);
		second = draw_worker(n);
		if (n == 1) begin
			pick = first;
		end else begin
			tries = 0;
			while (first == second && tries < REDRAW_LIMIT) begin
				second = draw_worker(n);
				tries++;
			end
			// give up on redrawing and take the neighbor
			if (first == second) begin
				second = (first + 1) % n;
			end
			pick = (load_tab[first] > load_tab[second]) ? second : first;
		end
		sum = load_tab[pick] + it.item_size;
		load_tab[pick] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
		if (count_tab[pick] != '1) begin
			count_tab[pick] = count_tab[pick] + 1'b1;
		end
		r.chosen_worker = WORKER_W'(pick);
		r.worker_load = load_tab[pick];
		r.worker_items = count_tab[pick];
		r.last_item_res = it.last_item;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tclb_result_t want;
		if (!arst_n) begin
			wc_reg = WC_RESET;
			rng = SEED_RESET;
			for (int k = 0; k < MAX_WORKERS; k++) begin
				load_tab[k] = '0;
				count_tab[k] = '0;
			end
			expected_placements.delete();
		end else begin
			// compare before queuing, a result never belongs to the item accepted with it
			if (result_valid) begin
				if (expected_placements.size() == 0) begin
					$error("result with no placement pending: worker %0d load %0d",
						result.chosen_worker, result.worker_load);
					mismatches++;
				end else begin
					want = expected_placements.pop_front();
					if (result.chosen_worker !== want.chosen_worker) begin
						$error("chosen_worker: expected %0d, got %0d",
							want.chosen_worker, result.chosen_worker);
						mismatches++;
					end
					if (result.worker_load !== want.worker_load) begin
						$error("worker_load: expected %0d, got %0d",
							want.worker_load, result.worker_load);
						mismatches++;
					end
					if (result.worker_items !== want.worker_items) begin
						$error("worker_items: expected %0d, got %0d",
							want.worker_items, result.worker_items);
						mismatches++;
					end
					if (result.last_item_res !== want.last_item_res) begin
						$error("last_item_res: expected %0d, got %0d",
							want.last_item_res, result.last_item_res);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_WORKER_COUNT) begin
					wc_reg = cfg_data[WC_W-1:0];
				end else if (cfg_index == REG_RANDOM_SEED) begin
					rng = (cfg_data == '0) ? SEED_RESET : cfg_data[SEED_W-1:0];
				end
			end
			if (start && !busy) begin
				place_item(item, want);
				expected_placements.push_back(want);
			end
		end
		fail_count <= mismatches;
		pending <= expected_placements.size();
	end

endmodule

[sim/two_choice_load_balancer_tb.sv]
// testbench top: drives items and register writes into the load balancer and gives the verdict
module two_choice_load_balancer_tb;
	import tclb_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	tclb_item_t            item;
	logic                  result_valid;
	tclb_result_t          result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    burst_left;
	bit                    gaps_on;

	logic [ITEM_SIZE_W-1:0] directed_sizes [12] = '{
		40'd1, '1, '0, 40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h80_0000_0000,
		'1, '0, 40'd12, 40'h00_FFFF_FFFF, 40'hFF_0000_0000, 40'd2
	};

	two_choice_load_balancer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tclb_placement_checker u_placement_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[two_choice_load_balancer] ERROR");
		$finish;
	end

	function automatic logic [ITEM_SIZE_W-1:0] pick_size(input bit heavy);
		logic [ITEM_SIZE_W-1:0] s;
		// near-maximum sizes drive a single worker into saturation
		if (heavy) return '1 - ITEM_SIZE_W'($urandom_range(0, 1 << 20));
		case ($urandom_range(0, 7))
			0: s = '0;
			1: s = '1;
			2: s = ITEM_SIZE_W'($urandom_range(1, 255));
			3: s = ITEM_SIZE_W'(1) << $urandom_range(0, ITEM_SIZE_W - 1);
			4: s = ~(ITEM_SIZE_W'(1) << $urandom_range(0, ITEM_SIZE_W - 1));
			5: s = ITEM_SIZE_W'($urandom_range(0, 1 << 20));
			default: s = ITEM_SIZE_W'({$urandom, $urandom});
		endcase
		return s;
	endfunction

	// holds start until the transfer, then maybe idles after a burst
	task automatic send_item(input logic [ITEM_SIZE_W-1:0] size, input logic last);
		start <= 1'b1;
		item.item_size <= size;
		item.last_item <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 110)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [WC_W-1:0] wc, input logic [SEED_W-1:0] seed,
		input int count, input bit heavy);
		logic [CFG_DATA_W-1:0] data;
		// junk in the upper bits of the worker count write
		data = $urandom;
		data[WC_W-1:0] = wc;
		write_reg(REG_WORKER_COUNT, data);
		write_reg(REG_RANDOM_SEED, seed);
		for (int i = 0; i < count; i++) begin
			send_item(pick_size(heavy), $urandom_range(0, 7) == 0);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gaps_on = 1'b1;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: four workers, seed one
		foreach (directed_sizes[k]) begin
			send_item(directed_sizes[k], k[0]);
		end
		drain();

		run_phase(WC_W'(2), 32'd0, 60, 1'b0);
		run_phase(WC_W'(16), 32'hFFFF_FFFF, 100, 1'b0);
		run_phase(WC_W'(0), $urandom, 30, 1'b0);
		gaps_on = 1'b0;
		run_phase(WC_W'(31), $urandom, 100, 1'b0);
		gaps_on = 1'b1;
		run_phase(WC_W'($urandom_range(3, 15)), $urandom, 100, 1'b0);
		run_phase(WC_W'($urandom_range(2, 16)), $urandom, 80, 1'b0);
		run_phase(WC_W'(1), 32'd1, 270, 1'b1);
		run_phase(WC_W'(2), $urandom, 60, 1'b0);
		run_phase(WC_W'(16), $urandom, 60, 1'b0);

		if (fail_count == 0) begin
			$display("[two_choice_load_balancer] OK");
		end else begin
			$display("[two_choice_load_balancer] ERROR");
		end
		$finish;
	end

endmodule
